### hw/rtl/ecc_pkg.sv
// ecc_pkg: shared types and constants for the elevator car controller
// used by ecc_cfg_regs, ecc_car_core and elevator_car_controller_top
`default_nettype none

package ecc_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_FLOOR_HEIGHT  = 3'd0;
    localparam logic [2:0] REG_STEP_SIZE     = 3'd1;
    localparam logic [2:0] REG_PERSON_WEIGHT = 3'd2;
    localparam logic [2:0] REG_MAX_LOAD      = 3'd3;
    localparam logic [2:0] REG_WAIT_TICKS    = 3'd4;

    // configuration reset values
    localparam logic [9:0]  FLOOR_HEIGHT_RST  = 10'd100;
    localparam logic [7:0]  STEP_SIZE_RST     = 8'd4;
    localparam logic [7:0]  PERSON_WEIGHT_RST = 8'd70;
    localparam logic [11:0] MAX_LOAD_RST      = 12'd600;
    localparam logic [15:0] WAIT_TICKS_RST    = 16'd250;

    // item kinds
    localparam logic FUNC_CALL = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam logic [7:0] PASSENGER_MAX = 8'hFF;

    typedef struct packed {
        logic [9:0]  floor_height;
        logic [7:0]  step_size;
        logic [7:0]  person_weight;
        logic [11:0] max_load;
        logic [15:0] wait_ticks;
    } cfg_t;

    typedef struct packed {
        logic       func;
        logic [2:0] floor;
        logic [3:0] board_count;
        logic [3:0] alight_count;
    } item_t;

    typedef struct packed {
        logic [2:0]  current_floor;
        logic        moving;
        logic        going_up;
        logic [15:0] position;
        logic [7:0]  passengers;
        logic [15:0] load_mass;
        logic        overload;
        logic        arrived;
        logic        dwelling;
    } res_t;

endpackage

`default_nettype wire

### hw/rtl/ecc_cfg_regs.sv
// ecc_cfg_regs: configuration register file written over the cfg channel
// depends on ecc_pkg
`default_nettype none

module ecc_cfg_regs (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         wr_en,
    input  wire logic [2:0]   wr_index,
    input  wire logic [15:0]  wr_data,
    output ecc_pkg::cfg_t     cfg
);
    import ecc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // register write decode, unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_FLOOR_HEIGHT:  cfg_next.floor_height  = wr_data[9:0];
                REG_STEP_SIZE:     cfg_next.step_size     = wr_data[7:0];
                REG_PERSON_WEIGHT: cfg_next.person_weight = wr_data[7:0];
                REG_MAX_LOAD:      cfg_next.max_load      = wr_data[11:0];
                REG_WAIT_TICKS:    cfg_next.wait_ticks    = wr_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.floor_height  <= FLOOR_HEIGHT_RST;
            cfg_reg.step_size     <= STEP_SIZE_RST;
            cfg_reg.person_weight <= PERSON_WEIGHT_RST;
            cfg_reg.max_load      <= MAX_LOAD_RST;
            cfg_reg.wait_ticks    <= WAIT_TICKS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### hw/rtl/ecc_car_core.sv
// ecc_car_core: car state registers and the single-pass update for one item
// depends on ecc_pkg
`default_nettype none

module ecc_car_core #(
    parameter int FLOOR_COUNT = 6
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           step_en,
    input  wire ecc_pkg::item_t item,
    input  wire ecc_pkg::cfg_t  cfg,
    output ecc_pkg::res_t       res
);
    import ecc_pkg::*;

    localparam logic [3:0] FLOOR_LIM = 4'(FLOOR_COUNT);

    logic        moving_reg,  moving_next;
    logic        up_reg,      up_next;
    logic [2:0]  floor_reg,   floor_next;
    logic [2:0]  target_reg,  target_next;
    logic [15:0] height_reg,  height_next;
    logic [7:0]  aboard_reg,  aboard_next;
    logic        dwell_reg,   dwell_next;
    logic [15:0] wait_reg,    wait_next;
    logic        run_reg,     run_next;
    logic        ret_reg,     ret_next;

    logic [12:0] tgt_height;
    logic [16:0] up_sum;
    logic [16:0] down_lim;
    logic [7:0]  leave;
    logic [7:0]  aboard_left;
    logic [8:0]  board_sum;
    logic [16:0] load_new;
    logic        load_ok;
    logic [7:0]  aboard_arr;
    logic [15:0] mass_now;
    logic [15:0] mass_keep;
    logic [15:0] mass_sat;
    logic [15:0] mass_arr;
    logic [15:0] mass_out;
    logic        arr;
    logic        ovl;
    logic        call_ok;

    // target height and motion compares
    assign tgt_height = {10'd0, target_reg} * {3'd0, cfg.floor_height};
    assign up_sum     = {1'b0, height_reg} + {9'd0, cfg.step_size};
    assign down_lim   = {4'd0, tgt_height} + {9'd0, cfg.step_size};

    // arrival: alighting capped at the count aboard, then the load check
    assign leave       = ({4'd0, item.alight_count} < aboard_reg) ?
                         {4'd0, item.alight_count} : aboard_reg;
    assign aboard_left = aboard_reg - leave;
    assign board_sum   = {1'b0, aboard_left} + {5'd0, item.board_count};
    assign load_new    = {8'd0, board_sum} * {9'd0, cfg.person_weight};
    assign load_ok     = load_new <= {5'd0, cfg.max_load};

    // mass candidates side by side so no product feeds another
    assign mass_now  = {8'd0, aboard_reg} * {8'd0, cfg.person_weight};
    assign mass_keep = {8'd0, aboard_left} * {8'd0, cfg.person_weight};
    assign mass_sat  = {cfg.person_weight, 8'd0} - {8'd0, cfg.person_weight};

    always_comb
    begin
        if (!load_ok)
        begin
            aboard_arr = aboard_left;
            mass_arr   = mass_keep;
        end
        else if (board_sum[8])
        begin
            aboard_arr = PASSENGER_MAX;
            mass_arr   = mass_sat;
        end
        else
        begin
            aboard_arr = board_sum[7:0];
            mass_arr   = load_new[15:0];
        end
    end

    assign call_ok = !moving_reg && (item.floor != floor_reg) &&
                     ({1'b0, item.floor} < FLOOR_LIM);

    // next state for the item in hand
    always_comb
    begin
        moving_next = moving_reg;
        up_next     = up_reg;
        floor_next  = floor_reg;
        target_next = target_reg;
        height_next = height_reg;
        aboard_next = aboard_reg;
        dwell_next  = dwell_reg;
        wait_next   = wait_reg;
        run_next    = run_reg;
        ret_next    = ret_reg;
        arr         = 1'b0;
        ovl         = 1'b0;
        mass_out    = mass_now;

        if (item.func == FUNC_CALL)
        begin
            if (call_ok)
            begin
                target_next = item.floor;
                up_next     = item.floor > floor_reg;
                moving_next = 1'b1;
            end
        end
        else
        begin
            // one motion period
            if (moving_reg)
            begin
                if (up_reg)
                begin
                    if (up_sum >= {4'd0, tgt_height})
                    begin
                        height_next = {3'd0, tgt_height};
                        arr         = 1'b1;
                    end
                    else
                    begin
                        height_next = up_sum[15:0];
                    end
                end
                else
                begin
                    if ({1'b0, height_reg} <= down_lim)
                    begin
                        height_next = {3'd0, tgt_height};
                        arr         = 1'b1;
                    end
                    else
                    begin
                        height_next = height_reg - {8'd0, cfg.step_size};
                    end
                end
            end

            if (arr)
            begin
                ovl         = !load_ok;
                aboard_next = aboard_arr;
                mass_out    = mass_arr;
                floor_next  = target_reg;
                moving_next = 1'b0;
                if ((aboard_arr == 8'd0) && (target_reg != 3'd0))
                begin
                    dwell_next = 1'b0;
                    ret_next   = 1'b1;
                end
                else
                begin
                    dwell_next = 1'b1;
                    ret_next   = 1'b0;
                end
                wait_next = cfg.wait_ticks;
                run_next  = 1'b1;
            end
            else if (run_reg)
            begin
                // wait timer countdown and expiry
                if (wait_reg <= 16'd1)
                begin
                    wait_next = 16'd0;
                    run_next  = 1'b0;
                    if (ret_reg)
                    begin
                        if ((aboard_reg == 8'd0) && !moving_reg && !dwell_reg &&
                            (floor_reg != 3'd0))
                        begin
                            target_next = 3'd0;
                            up_next     = 1'b0;
                            moving_next = 1'b1;
                        end
                    end
                    else
                    begin
                        dwell_next = 1'b0;
                    end
                end
                else
                begin
                    wait_next = wait_reg - 16'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            moving_reg <= 1'b0;
            up_reg     <= 1'b1;
            floor_reg  <= 3'd0;
            target_reg <= 3'd0;
            height_reg <= 16'd0;
            aboard_reg <= 8'd0;
            dwell_reg  <= 1'b0;
            wait_reg   <= 16'd0;
            run_reg    <= 1'b0;
            ret_reg    <= 1'b0;
        end
        else if (step_en)
        begin
            moving_reg <= moving_next;
            up_reg     <= up_next;
            floor_reg  <= floor_next;
            target_reg <= target_next;
            height_reg <= height_next;
            aboard_reg <= aboard_next;
            dwell_reg  <= dwell_next;
            wait_reg   <= wait_next;
            run_reg    <= run_next;
            ret_reg    <= ret_next;
        end
    end

    // result of this item
    always_comb
    begin
        res.current_floor = floor_next;
        res.moving        = moving_next;
        res.going_up      = up_next;
        res.position      = height_next;
        res.passengers    = aboard_next;
        res.load_mass     = mass_out;
        res.overload      = ovl;
        res.arrived       = arr;
        res.dwelling      = dwell_next;
    end

endmodule

`default_nettype wire

### hw/rtl/elevator_car_controller_top.sv
// elevator_car_controller_top: input register, car core and result register
// depends on ecc_pkg, ecc_cfg_regs and ecc_car_core
//
// Usage
//   in channel: one beat is a floor call (func 0) or a time tick (func 1)
//   with floor, board_count and alight_count; out channel: one result beat
//   per input beat, in order, carrying the car state after that item. cfg
//   channel: cfg_index picks one of five registers (floor height, step size,
//   person weight, max load, wait ticks), cfg_data is the value; cfg_ready is
//   always high; writes must be made only while the block idles; not enforced.
// Timing
//   a beat is held in the input register, is processed by the core in one
//   pass and lands in the result register, where out_valid rises; a stall on
//   out_ready can hold it in either register. One beat per cycle is sustained
//   while out_ready stays high; the core updates the car state in one pass.
// Reset
//   rst_n clears both pipeline valid flags, the car state (floor 0, idle,
//   empty, direction up, timer stopped) and loads the register defaults.
// Stall
//   while out_ready is low the result holds; the input register still takes
//   one more beat, then in_ready drops until the result is taken.
`default_nettype none

module elevator_car_controller_top #(
    parameter int FLOOR_COUNT = 6
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // configuration
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [15:0]  cfg_data,
    // items
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic         func,
    input  wire logic [2:0]   floor,
    input  wire logic [3:0]   board_count,
    input  wire logic [3:0]   alight_count,
    // results
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [2:0]        current_floor,
    output logic              moving,
    output logic              going_up,
    output logic [15:0]       position,
    output logic [7:0]        passengers,
    output logic [15:0]       load_mass,
    output logic              overload,
    output logic              arrived,
    output logic              dwelling
);
    import ecc_pkg::*;

    cfg_t  cfg;
    item_t in_reg;
    item_t in_next;
    logic  in_vld_reg;
    logic  in_vld_next;
    res_t  res;
    res_t  out_reg;
    res_t  out_next;
    logic  out_vld_reg;
    logic  out_vld_next;
    logic  in_take;
    logic  advance;

    assign cfg_ready = 1'b1;

    ecc_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // handshake: the input register moves on whenever the result slot frees
    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        in_next = in_reg;
        if (in_take)
        begin
            in_next.func         = func;
            in_next.floor        = floor;
            in_next.board_count  = board_count;
            in_next.alight_count = alight_count;
        end
    end

    assign in_vld_next  = in_take ? 1'b1 : (advance ? 1'b0 : in_vld_reg);
    assign out_vld_next = advance ? 1'b1 : (out_ready ? 1'b0 : out_vld_reg);
    assign out_next     = advance ? res : out_reg;

    ecc_car_core #(
        .FLOOR_COUNT (FLOOR_COUNT)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (in_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        in_reg  <= in_next;
        out_reg <= out_next;
    end

    assign out_valid     = out_vld_reg;
    assign current_floor = out_reg.current_floor;
    assign moving        = out_reg.moving;
    assign going_up      = out_reg.going_up;
    assign position      = out_reg.position;
    assign passengers    = out_reg.passengers;
    assign load_mass     = out_reg.load_mass;
    assign overload      = out_reg.overload;
    assign arrived       = out_reg.arrived;
    assign dwelling      = out_reg.dwelling;

`ifndef SYNTH
    // a completed trip leaves the car standing
    a_arrive_stops: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_reg.arrived |-> !out_reg.moving)
        else $error("arrival reported while still moving");

    // refused boarding only happens on an arrival
    a_ovl_on_arrive: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_reg.overload |-> out_reg.arrived)
        else $error("overload without arrival");

    // a held beat in the input register is never dropped
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && !advance |=> in_vld_reg)
        else $error("input beat lost while stalled");

    // a result beat appears in the cycle after the core advances
    a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_vld_reg)
        else $error("processed beat did not reach the result register");
`endif

endmodule

`default_nettype wire

### tb/ecc_car_checker.sv
`timescale 1ns / 100ps
// ecc_car_checker: watches the config, item and result channels of the car controller,
// predicts the car state after every item beat and compares it with the result beat
// depends on ecc_pkg for register indexes, item kinds and the result struct

module ecc_car_checker #(
    parameter int FLOOR_COUNT = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        func,
    input  logic [2:0]  floor,
    input  logic [3:0]  board_count,
    input  logic [3:0]  alight_count,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  current_floor,
    input  logic        moving,
    input  logic        going_up,
    input  logic [15:0] position,
    input  logic [7:0]  passengers,
    input  logic [15:0] load_mass,
    input  logic        overload,
    input  logic        arrived,
    input  logic        dwelling,
    output int          mismatch_count,
    output int          pending,
    output int          arrival_count,
    output int          refusal_count,
    output int          return_count
);
    import ecc_pkg::*;

    // register mirror
    int unsigned fh, stp, pw, ml, wt;

    // car state mirror
    int unsigned floor_now, floor_goal, height, aboard, wait_left;
    logic        moving_f, up_f, dwell_f, timer_on, timer_return;

    res_t car_states_due[$];
    int   errs, arrivals, refusals, returns;

    // a trip starts only from idle, to another floor that exists
    task automatic start_trip_to(input int unsigned fl);
        if (!moving_f && fl != floor_now && fl < FLOOR_COUNT)
        begin
            floor_goal = fl;
            up_f       = (fl > floor_now);
            moving_f   = 1'b1;
        end
    endtask

    // next car state for one item beat
    task automatic step_car(input logic f, input logic [2:0] fl, input logic [3:0] bc,
                            input logic [3:0] ac, output res_t r);
        int unsigned tgt, leave, boarders, leavers;
        logic        ovl, arr;
        ovl      = 1'b0;
        arr      = 1'b0;
        boarders = bc;
        leavers  = ac;
        if (f == FUNC_CALL)
        begin
            start_trip_to(fl);
        end
        else
        begin
            // motion step, clamped at the target height
            if (moving_f)
            begin
                tgt = floor_goal * fh;
                if (up_f)
                begin
                    if (height + stp >= tgt)
                    begin
                        height = tgt;
                        arr    = 1'b1;
                    end
                    else
                        height = height + stp;
                end
                else
                begin
                    if (height <= tgt + stp)
                    begin
                        height = tgt;
                        arr    = 1'b1;
                    end
                    else
                        height = height - stp;
                end
                height = height & 32'hFFFF;
            end
            // arrival: leavers first, then boarders if the load allows
            if (arr)
            begin
                leave     = (leavers < aboard) ? leavers : aboard;
                aboard    = aboard - leave;
                floor_now = floor_goal;
                moving_f  = 1'b0;
                if ((aboard + boarders) * pw <= ml)
                begin
                    aboard = aboard + boarders;
                    if (aboard > 255)
                        aboard = 255;
                end
                else
                    ovl = 1'b1;
                if (aboard == 0 && floor_now != 0)
                begin
                    dwell_f      = 1'b0;
                    timer_return = 1'b1;
                end
                else
                begin
                    dwell_f      = 1'b1;
                    timer_return = 1'b0;
                end
                wait_left = wt;
                timer_on  = 1'b1;
                arrivals++;
                if (ovl)
                    refusals++;
            end
            // wait timer countdown and expiry
            else if (timer_on)
            begin
                if (wait_left <= 1)
                begin
                    wait_left = 0;
                    timer_on  = 1'b0;
                    if (timer_return)
                    begin
                        if (aboard == 0 && !moving_f && !dwell_f)
                        begin
                            start_trip_to(0);
                            if (moving_f)
                                returns++;
                        end
                    end
                    else
                        dwell_f = 1'b0;
                end
                else
                    wait_left = wait_left - 1;
            end
        end
        r.current_floor = floor_now[2:0];
        r.moving        = moving_f;
        r.going_up      = up_f;
        r.position      = height[15:0];
        r.passengers    = aboard[7:0];
        r.load_mass     = 16'((aboard * pw) & 32'hFFFF);
        r.overload      = ovl;
        r.arrived       = arr;
        r.dwelling      = dwell_f;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            errs++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        res_t got, want;
        if (!rst_n)
        begin
            fh           = FLOOR_HEIGHT_RST;
            stp          = STEP_SIZE_RST;
            pw           = PERSON_WEIGHT_RST;
            ml           = MAX_LOAD_RST;
            wt           = WAIT_TICKS_RST;
            floor_now    = 0;
            floor_goal   = 0;
            height       = 0;
            aboard       = 0;
            wait_left    = 0;
            moving_f     = 1'b0;
            up_f         = 1'b1;
            dwell_f      = 1'b0;
            timer_on     = 1'b0;
            timer_return = 1'b0;
            car_states_due.delete();
        end
        else
        begin
            // register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_FLOOR_HEIGHT:  fh  = cfg_data[9:0];
                    REG_STEP_SIZE:     stp = cfg_data[7:0];
                    REG_PERSON_WEIGHT: pw  = cfg_data[7:0];
                    REG_MAX_LOAD:      ml  = cfg_data[11:0];
                    REG_WAIT_TICKS:    wt  = cfg_data;
                    default: ;
                endcase
            end
            // result beat against the oldest prediction
            if (out_valid && out_ready)
            begin
                if (car_states_due.size() == 0)
                begin
                    $display("%0t: result beat with nothing predicted, position %0d",
                             $time, position);
                    errs++;
                end
                else
                begin
                    want = car_states_due.pop_front();
                    check_field("current_floor", want.current_floor, current_floor);
                    check_field("moving", want.moving, moving);
                    check_field("going_up", want.going_up, going_up);
                    check_field("position", want.position, position);
                    check_field("passengers", want.passengers, passengers);
                    check_field("load_mass", want.load_mass, load_mass);
                    check_field("overload", want.overload, overload);
                    check_field("arrived", want.arrived, arrived);
                    check_field("dwelling", want.dwelling, dwelling);
                end
            end
            // item beat into the predictor
            if (in_valid && in_ready)
            begin
                step_car(func, floor, board_count, alight_count, got);
                car_states_due.push_back(got);
            end
        end
        mismatch_count <= errs;
        pending        <= car_states_due.size();
        arrival_count  <= arrivals;
        refusal_count  <= refusals;
        return_count   <= returns;
    end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// tb: stimulus and verdict for elevator_car_controller_top, with ecc_car_checker
// beside the block doing prediction and comparison
// depends on ecc_pkg, elevator_car_controller_top and ecc_car_checker

module tb;
    import ecc_pkg::*;

    localparam int FLOORS = 6;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index    = REG_FLOOR_HEIGHT;
    logic [15:0] cfg_data     = '0;
    logic        in_valid     = 1'b0;
    logic        in_ready;
    logic        func         = FUNC_TICK;
    logic [2:0]  floor        = '0;
    logic [3:0]  board_count  = '0;
    logic [3:0]  alight_count = '0;
    logic        out_valid;
    logic        out_ready    = 1'b0;
    logic [2:0]  current_floor;
    logic        moving, going_up, overload, arrived, dwelling;
    logic [15:0] position, load_mass;
    logic [7:0]  passengers;

    int mismatches, pending, arrivals, refusals, returns;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int items_sent  = 0;
    int hold_cnt    = 0;
    logic hold_req  = 1'b0;
    logic hold_done = 1'b0;

    elevator_car_controller_top #(.FLOOR_COUNT(FLOORS)) uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .floor(floor), .board_count(board_count), .alight_count(alight_count),
        .out_valid(out_valid), .out_ready(out_ready),
        .current_floor(current_floor), .moving(moving), .going_up(going_up),
        .position(position), .passengers(passengers), .load_mass(load_mass),
        .overload(overload), .arrived(arrived), .dwelling(dwelling)
    );

    ecc_car_checker #(.FLOOR_COUNT(FLOORS)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .floor(floor), .board_count(board_count), .alight_count(alight_count),
        .out_valid(out_valid), .out_ready(out_ready),
        .current_floor(current_floor), .moving(moving), .going_up(going_up),
        .position(position), .passengers(passengers), .load_mass(load_mass),
        .overload(overload), .arrived(arrived), .dwelling(dwelling),
        .mismatch_count(mismatches), .pending(pending),
        .arrival_count(arrivals), .refusal_count(refusals), .return_count(returns)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side: random back-pressure plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            out_ready <= 1'b0;
            hold_cnt  <= hold_cnt + 1;
            if (hold_cnt == 79)
                hold_done <= 1'b1;
        end
        else
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // one item beat, with a random gap in front of it
    task automatic send_item(input logic f, input logic [2:0] fl, input logic [3:0] bc,
                             input logic [3:0] ac);
        int gap;
        gap = 0;
        while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        func         <= f;
        floor        <= fl;
        board_count  <= bc;
        alight_count <= ac;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // hold the sender until every predicted result has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // all five registers, written once the block is drained
    task automatic load_setting(input logic [15:0] fh, input logic [15:0] step,
                                input logic [15:0] pw, input logic [15:0] ml,
                                input logic [15:0] wt);
        logic [2:0]  idx [5];
        logic [15:0] val [5];
        idx = '{REG_FLOOR_HEIGHT, REG_STEP_SIZE, REG_PERSON_WEIGHT, REG_MAX_LOAD,
                REG_WAIT_TICKS};
        val = '{fh, step, pw, ml, wt};
        drain();
        cfg_valid <= 1'b1;
        for (int i = 0; i < 5; i++)
        begin
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // mostly ticks so trips and timers run their course, calls mixed in
    task automatic random_items(input int count, input int call_pct, input bit fill_car);
        logic       f;
        logic [3:0] bc, ac;
        repeat (count)
        begin
            f = ($urandom_range(99) < call_pct) ? FUNC_CALL : FUNC_TICK;
            if (fill_car)
            begin
                bc = 4'($urandom_range(15, 8));
                ac = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'd0;
            end
            else
            begin
                bc = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(4));
                ac = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(4));
            end
            send_item(f, 3'($urandom_range(7)), bc, ac);
        end
    endtask

    task automatic set_idle(input int tx, input int rx);
        tx_idle_pct  = tx;
        rx_idle_pct <= rx;
    endtask

    initial
    begin : stimulus
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_idle(11, 64);

        // reset settings: ignored calls, then a trip started and a call during it
        send_item(FUNC_TICK, 3'd0, 4'd0, 4'd0);
        send_item(FUNC_CALL, 3'd0, 4'd0, 4'd0);
        send_item(FUNC_CALL, 3'd6, 4'd0, 4'd0);
        send_item(FUNC_CALL, 3'd7, 4'd0, 4'd0);
        send_item(FUNC_CALL, 3'd5, 4'd0, 4'd0);
        send_item(FUNC_TICK, 3'd0, 4'd0, 4'd0);
        send_item(FUNC_TICK, 3'd0, 4'd0, 4'd0);
        send_item(FUNC_CALL, 3'd2, 4'd0, 4'd0);

        // one-tick trips mid-trip: boarding, dwell expiry, overload, return to floor 0
        load_setting(16'd1, 16'd255, 16'd255, 16'd4095, 16'd1);
        send_item(FUNC_TICK, 3'd0, 4'd15, 4'd15);
        send_item(FUNC_TICK, 3'd0, 4'd0, 4'd0);
        send_item(FUNC_CALL, 3'd0, 4'd0, 4'd0);
        send_item(FUNC_TICK, 3'd0, 4'd2, 4'd0);
        send_item(FUNC_CALL, 3'd3, 4'd0, 4'd0);
        send_item(FUNC_TICK, 3'd0, 4'd0, 4'd15);
        send_item(FUNC_TICK, 3'd0, 4'd0, 4'd0);
        send_item(FUNC_TICK, 3'd0, 4'd0, 4'd0);
        send_item(FUNC_TICK, 3'd0, 4'd0, 4'd0);

        // random phases, sender light and receiver heavy idling
        load_setting(16'd10, 16'd3, 16'd70, 16'd600, 16'd5);
        random_items(100, 15, 1'b0);
        load_setting(16'd1023, 16'd255, 16'd200, 16'd1000, 16'd2);
        random_items(70, 15, 1'b0);
        // light passengers and a big limit to drive the count to saturation
        load_setting(16'd7, 16'd7, 16'd1, 16'd4095, 16'd3);
        random_items(120, 15, 1'b1);

        // sender heavy and receiver light idling
        set_idle(64, 11);
        load_setting(16'd1, 16'd1, 16'd255, 16'd0, 16'd1);
        random_items(80, 20, 1'b0);
        // zero step leaves a trip stuck, the next setting resumes it mid-trip
        load_setting(16'd50, 16'd0, 16'd90, 16'd2000, 16'd65535);
        random_items(40, 20, 1'b0);
        load_setting(16'd50, 16'd20, 16'd90, 16'd2000, 16'd4);
        random_items(100, 15, 1'b0);

        // no idling, one long result stall while items keep coming
        set_idle(0, 0);
        load_setting(16'd13, 16'd5, 16'd120, 16'd700, 16'd6);
        hold_req <= 1'b1;
        random_items(130, 15, 1'b0);
        load_setting(16'd100, 16'd4, 16'd70, 16'd600, 16'd250);
        random_items(60, 15, 1'b0);

        // wrap up
        drain();
        repeat (4) @(posedge clk);
        $display("run covered %0d item beats under nine register settings", items_sent);
        $display("trips completed %0d, boardings refused %0d, automatic returns %0d",
                 arrivals, refusals, returns);
        if (mismatches == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : watchdog
        #5000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
